// ===== src/assert_macros.svh =====
// Assertion macros for the filter gain checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked assertion, off while reset is asserted
`define FDFG_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// clocked assertion, checked during reset too
`define FDFG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== src/fdfg_pkg.sv =====
// Types, constants and helper functions of the frequency domain filter gain block
`default_nettype none
package fdfg_pkg;

  localparam int unsigned WIDTH  = 512;
  localparam int unsigned HEIGHT = 512;
  localparam logic [9:0] CENTER_X = 10'(WIDTH / 2);
  localparam logic [9:0] CENTER_Y = 10'(HEIGHT / 2);

  localparam logic [15:0] ONE_Q12   = 16'd4096;
  localparam logic [16:0] Q16_ONE   = 17'h10000;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [20:0] X_CAP     = 21'h1FFFFF;

  localparam int unsigned EXP_STAGES = 16;
  localparam int unsigned DIV_NUM_W  = 40;
  localparam int unsigned DIV_DEN_W  = 33;
  localparam int unsigned DIV_STAGES = DIV_NUM_W;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [3:0] REG_FILTER_KIND = 4'd0;
  localparam logic [3:0] REG_SHAPE_KIND  = 4'd1;
  localparam logic [3:0] REG_HOMOMORPHIC = 4'd2;
  localparam logic [3:0] REG_CUTOFF      = 4'd3;
  localparam logic [3:0] REG_BUTTER_ORD  = 4'd4;
  localparam logic [3:0] REG_GAIN_HIGH   = 4'd5;
  localparam logic [3:0] REG_GAIN_LOW    = 4'd6;
  localparam logic [3:0] REG_SHARPNESS   = 4'd7;

  localparam logic [1:0] FK_LOW  = 2'd1;
  localparam logic [1:0] FK_HIGH = 2'd2;

  localparam logic [1:0] SHAPE_IDEAL  = 2'd0;
  localparam logic [1:0] SHAPE_BUTTER = 2'd1;
  localparam logic [1:0] SHAPE_GAUSS  = 2'd2;

  typedef struct packed {
    logic [8:0]         col;
    logic [8:0]         row;
    logic signed [31:0] re_in;
    logic signed [31:0] im_in;
  } in_t;

  typedef struct packed {
    logic signed [31:0] re_out;
    logic signed [31:0] im_out;
    logic [15:0]        gain;
  } out_t;

  typedef struct packed {
    logic [1:0]  filter_kind;
    logic [1:0]  shape_kind;
    logic        homomorphic_enable;
    logic [9:0]  cutoff;
    logic [3:0]  butter_order;
    logic [15:0] gain_high;
    logic [15:0] gain_low;
    logic [15:0] sharpness;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    filter_kind: 2'd0, shape_kind: 2'd2, homomorphic_enable: 1'b0, cutoff: 10'd30,
    butter_order: 4'd1, gain_high: 16'd4096, gain_low: 16'd0, sharpness: 16'd4096
  };

  typedef enum logic [1:0] {
    MODE_FIXED,
    MODE_BUTTER,
    MODE_GAUSS
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic               low_pass;
    logic [15:0]        gfix;
    logic [17:0]        d2;
    logic signed [31:0] re;
    logic signed [31:0] im;
  } job_t;

  typedef struct packed {
    mode_e              mode;
    logic               low_pass;
    logic [15:0]        gfix;
    logic [16:0]        e;
    logic signed [31:0] re;
    logic signed [31:0] im;
  } side_t;

  function automatic logic [19:0] cutoff_sq(logic [9:0] c);
    logic [9:0] d;
    d = (c == 10'd0) ? 10'd1 : c;
    return 20'(d) * 20'(d);
  endfunction

  function automatic logic [15:0] pow2_neg_bit(logic [3:0] b);
    logic [15:0] v;
    unique case (b)
      4'd0:  v = 16'd46341;
      4'd1:  v = 16'd55109;
      4'd2:  v = 16'd60097;
      4'd3:  v = 16'd62757;
      4'd4:  v = 16'd64132;
      4'd5:  v = 16'd64830;
      4'd6:  v = 16'd65182;
      4'd7:  v = 16'd65359;
      4'd8:  v = 16'd65447;
      4'd9:  v = 16'd65492;
      4'd10: v = 16'd65514;
      4'd11: v = 16'd65525;
      4'd12: v = 16'd65530;
      4'd13: v = 16'd65533;
      4'd14: v = 16'd65535;
      4'd15: v = 16'd65535;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== src/frequency_domain_filter_gain.sv =====
// The path to out_valid_o runs through the job queue, two 40-stage one-bit-per-stage dividers
// and a 16-stage multiply chain.
// Throughput: one bin per cycle; a stalled output freezes the back pipeline and
// the 4-entry job queue absorbs input until it fills.
// Reset: configuration returns to its defaults, queue empties, pipeline valids clear.
`default_nettype none
module frequency_domain_filter_gain import fdfg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t cfg_q;
  job_t front_job, head_job;
  logic fifo_full, fifo_empty, fifo_pop, fifo_push;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FILTER_KIND: cfg_q.filter_kind        <= cfg_data_i[1:0];
        REG_SHAPE_KIND:  cfg_q.shape_kind         <= cfg_data_i[1:0];
        REG_HOMOMORPHIC: cfg_q.homomorphic_enable <= cfg_data_i[0];
        REG_CUTOFF:      cfg_q.cutoff             <= cfg_data_i[9:0];
        REG_BUTTER_ORD:  cfg_q.butter_order       <= cfg_data_i[3:0];
        REG_GAIN_HIGH:   cfg_q.gain_high          <= cfg_data_i;
        REG_GAIN_LOW:    cfg_q.gain_low           <= cfg_data_i;
        REG_SHARPNESS:   cfg_q.sharpness          <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = fifo_full;
  assign fifo_push  = in_valid_i && !fifo_full;

  fdfg_front u_front (
    .in_data_i (in_data_i),
    .cfg_i     (cfg_q),
    .job_o     (front_job)
  );

  fdfg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (front_job),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .empty_o (fifo_empty),
    .data_o  (head_job)
  );

  fdfg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (!fifo_empty),
    .head_i       (head_job),
    .pop_o        (fifo_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule
`default_nettype wire

// ===== src/fdfg_fifo.sv =====
// Short job queue between the classifying front and the arithmetic back
`default_nettype none
module fdfg_fifo import fdfg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t data_o
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);

  job_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   count_q, count_d;

  assign full_o  = (count_q == (PTR_W + 1)'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? PTR_W'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop_i ? PTR_W'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q + (PTR_W + 1)'(push_i) - (PTR_W + 1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ===== src/fdfg_front.sv =====
// Front end: squared distance to the centre and per-bin gain classification
`default_nettype none
module fdfg_front import fdfg_pkg::*; (
  input  in_t  in_data_i,
  input  cfg_t cfg_i,
  output job_t job_o
);

  logic signed [9:0]  dx, dy;
  logic signed [19:0] dx2, dy2;
  logic [17:0]        d2;
  logic [19:0]        t2;
  logic [1:0]         shape;
  logic               low_pass;

  always_comb begin
    dx  = signed'(10'({1'b0, in_data_i.col}) - CENTER_X);
    dy  = signed'(10'({1'b0, in_data_i.row}) - CENTER_Y);
    dx2 = dx * dx;
    dy2 = dy * dy;
    d2  = 18'(dx2) + 18'(dy2);
    t2  = cutoff_sq(cfg_i.cutoff);
    low_pass = (cfg_i.filter_kind == FK_LOW);
    shape    = cfg_i.homomorphic_enable ? SHAPE_GAUSS : cfg_i.shape_kind;

    job_o.mode     = MODE_FIXED;
    job_o.low_pass = low_pass;
    job_o.gfix     = ONE_Q12;
    job_o.d2       = d2;
    job_o.re       = in_data_i.re_in;
    job_o.im       = in_data_i.im_in;

    if (cfg_i.filter_kind == FK_LOW || cfg_i.filter_kind == FK_HIGH) begin
      if (shape == SHAPE_IDEAL) begin
        job_o.gfix = ((20'(d2) <= t2) == low_pass) ? ONE_Q12 : '0;
      end else if (shape == SHAPE_BUTTER) begin
        if (!low_pass && d2 == '0) begin
          job_o.gfix = '0;
        end else begin
          job_o.mode = MODE_BUTTER;
        end
      end else begin
        job_o.mode = MODE_GAUSS;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/fdfg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side band
`default_nettype none
module fdfg_div import fdfg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  side_t                side_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output logic                 valid_o,
  output side_t                side_o,
  output logic [DIV_NUM_W-1:0] quo_o,
  output logic [DIV_DEN_W-1:0] rem_o,
  output logic [DIV_DEN_W-1:0] den_o
);

  logic [DIV_STAGES-1:0] v_q;
  logic [DIV_DEN_W-1:0]  rem_q [DIV_STAGES];
  logic [DIV_DEN_W-1:0]  rem_d [DIV_STAGES];
  logic [DIV_DEN_W-1:0]  den_q [DIV_STAGES];
  logic [DIV_NUM_W-1:0]  nq_q  [DIV_STAGES];
  logic [DIV_NUM_W-1:0]  nq_d  [DIV_STAGES];
  side_t                 side_q [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    logic [DIV_DEN_W-1:0] rem_in, den_in;
    logic [DIV_NUM_W-1:0] nq_in;
    logic [DIV_DEN_W:0]   trial;
    logic                 ge;
    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = den_i;
      assign nq_in  = num_i;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign nq_in  = nq_q[i-1];
    end
    assign trial    = {rem_in, nq_in[DIV_NUM_W-1]};
    assign ge       = (trial >= {1'b0, den_in});
    assign rem_d[i] = ge ? DIV_DEN_W'(trial - {1'b0, den_in}) : trial[DIV_DEN_W-1:0];
    assign nq_d[i]  = {nq_in[DIV_NUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DIV_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= rem_d[0];
      nq_q[0]   <= nq_d[0];
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
      for (int i = 1; i < DIV_STAGES; i++) begin
        rem_q[i]  <= rem_d[i];
        nq_q[i]   <= nq_d[i];
        den_q[i]  <= den_q[i-1];
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign valid_o = v_q[DIV_STAGES-1];
  assign side_o  = side_q[DIV_STAGES-1];
  assign quo_o   = nq_q[DIV_STAGES-1];
  assign rem_o   = rem_q[DIV_STAGES-1];
  assign den_o   = den_q[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== src/fdfg_back.sv =====
// Back end: gain arithmetic pipeline, gain application and output register
`default_nettype none
module fdfg_back import fdfg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic head_valid_i,
  input  job_t head_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  function automatic logic [31:0] apply_gain(logic [31:0] raw, logic [15:0] g);
    logic        neg;
    logic [31:0] mag;
    logic [48:0] prod;
    logic [36:0] q;
    neg  = raw[31];
    mag  = neg ? (~raw + 32'd1) : raw;
    prod = 49'(mag) * 49'(g) + 49'd2048;
    q    = prod[48:12];
    if (neg) begin
      return (q > 37'h080000000) ? 32'h80000000 : (~q[31:0] + 32'd1);
    end
    return (q > 37'h07FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
  endfunction

  logic en;
  logic [19:0] t2;
  logic [15:0] c_q12, hi, lo_raw, lo, delta;
  logic [3:0]  n_ord;
  logic [2:0]  n_m1;

  assign en    = !(out_valid_o && out_stall_i);
  assign pop_o = en && head_valid_i;

  always_comb begin
    t2     = cutoff_sq(cfg_i.cutoff);
    c_q12  = cfg_i.homomorphic_enable ? cfg_i.sharpness : ONE_Q12;
    hi     = cfg_i.homomorphic_enable ? cfg_i.gain_high : ONE_Q12;
    lo_raw = cfg_i.homomorphic_enable ? cfg_i.gain_low : '0;
    lo     = (lo_raw >= hi) ? '0 : lo_raw;
    delta  = hi - lo;
    if (cfg_i.butter_order == 4'd0) begin
      n_ord = 4'd1;
    end else if (cfg_i.butter_order > 4'd8) begin
      n_ord = 4'd8;
    end else begin
      n_ord = cfg_i.butter_order;
    end
    n_m1 = 3'(n_ord - 4'd1);
  end

  // numerator and divisor setup
  logic                 v0_q;
  side_t                s0_q, s0_d;
  logic [DIV_NUM_W-1:0] num0_q, num0_d;
  logic [DIV_DEN_W-1:0] den0_q, den0_d;
  logic [33:0]          cd2;

  always_comb begin
    cd2  = 34'(c_q12) * 34'(head_i.d2);
    s0_d = '{mode: head_i.mode, low_pass: head_i.low_pass, gfix: head_i.gfix,
             e: '0, re: head_i.re, im: head_i.im};
    unique case (head_i.mode)
      MODE_BUTTER: begin
        if (head_i.low_pass) begin
          num0_d = DIV_NUM_W'({head_i.d2, 16'h0000});
          den0_d = DIV_DEN_W'(t2);
        end else begin
          num0_d = DIV_NUM_W'({t2, 16'h0000});
          den0_d = DIV_DEN_W'(head_i.d2);
        end
      end
      MODE_GAUSS: begin
        num0_d = DIV_NUM_W'({cd2, 3'b000});
        den0_d = DIV_DEN_W'(t2);
      end
      default: begin
        num0_d = '0;
        den0_d = DIV_DEN_W'(1);
      end
    endcase
  end

  logic                 v1_div;
  side_t                s1_div;
  logic [DIV_NUM_W-1:0] q1;
  logic [DIV_DEN_W-1:0] r1, dn1;

  fdfg_div u_div_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v0_q),
    .side_i  (s0_q),
    .num_i   (num0_q),
    .den_i   (den0_q),
    .valid_o (v1_div),
    .side_o  (s1_div),
    .quo_o   (q1),
    .rem_o   (r1),
    .den_o   (dn1)
  );

  // ratio clamp and exponent scaling
  logic        v1_q;
  side_t       s1_q;
  logic [31:0] a1_q, a1_d, op1_q, op1_d, ratio;
  logic [20:0] x;
  logic [37:0] y;

  always_comb begin
    ratio = (|q1[DIV_NUM_W-1:32]) ? 32'hFFFFFFFF : q1[31:0];
    x     = (|q1[DIV_NUM_W-1:21]) ? X_CAP : q1[20:0];
    y     = 38'(x) * 38'(LOG2E_Q16);
    if (s1_div.mode == MODE_GAUSS) begin
      a1_d  = 32'(Q16_ONE);
      op1_d = 32'(y[37:16]);
    end else begin
      a1_d  = ratio;
      op1_d = ratio;
    end
  end

  // shared multiply chain: Butterworth power or 2^-fraction product
  logic [EXP_STAGES-1:0] sh_v_q;
  logic [31:0]           sh_a_q [EXP_STAGES];
  logic [31:0]           sh_a_d [EXP_STAGES];
  logic [31:0]           sh_op_q [EXP_STAGES];
  side_t                 sh_s_q [EXP_STAGES];

  for (genvar i = 0; i < EXP_STAGES; i++) begin : g_mul
    logic [31:0] a_in, op_in, mul_b;
    side_t       s_in;
    logic [63:0] prod;
    logic [47:0] prod_sh;
    logic        do_gauss, do_butter, apply;
    if (i == 0) begin : g_first
      assign a_in  = a1_q;
      assign op_in = op1_q;
      assign s_in  = s1_q;
    end else begin : g_next
      assign a_in  = sh_a_q[i-1];
      assign op_in = sh_op_q[i-1];
      assign s_in  = sh_s_q[i-1];
    end
    assign do_gauss  = (s_in.mode == MODE_GAUSS) && op_in[EXP_STAGES-1-i];
    assign do_butter = (s_in.mode == MODE_BUTTER) && (4'(i) < {1'b0, n_m1});
    assign apply     = do_gauss || do_butter;
    assign mul_b     = (s_in.mode == MODE_GAUSS) ? {16'h0000, pow2_neg_bit(4'(i))} : op_in;
    assign prod      = 64'(a_in) * 64'(mul_b);
    assign prod_sh   = prod[63:16];
    assign sh_a_d[i] = !apply ? a_in :
                       ((|prod_sh[47:32]) ? 32'hFFFFFFFF : prod_sh[31:0]);
  end

  // exponent shift, complement, Butterworth divisor
  logic                 v3_q;
  side_t                s3_q, s3_d;
  logic [DIV_NUM_W-1:0] num3_q, num3_d;
  logic [DIV_DEN_W-1:0] den3_q, den3_d;
  logic [31:0]          a_last;
  logic [5:0]           k_last;
  logic [16:0]          e0;

  always_comb begin
    a_last = sh_a_q[EXP_STAGES-1];
    k_last = sh_op_q[EXP_STAGES-1][21:16];
    e0     = (k_last >= 6'd17) ? '0 : 17'(a_last >> k_last);
    s3_d   = sh_s_q[EXP_STAGES-1];
    num3_d = '0;
    den3_d = DIV_DEN_W'(1);
    unique case (s3_d.mode)
      MODE_GAUSS: begin
        s3_d.e = s3_d.low_pass ? e0 : 17'(Q16_ONE - e0);
      end
      MODE_BUTTER: begin
        num3_d = DIV_NUM_W'(1) << 28;
        den3_d = DIV_DEN_W'(a_last) + DIV_DEN_W'(Q16_ONE);
      end
      default: begin
        s3_d.e = '0;
      end
    endcase
  end

  logic                 v4_div;
  side_t                s4_div;
  logic [DIV_NUM_W-1:0] q4;
  logic [DIV_DEN_W-1:0] r4, dn4;

  fdfg_div u_div_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .side_i  (s3_q),
    .num_i   (num3_q),
    .den_i   (den3_q),
    .valid_o (v4_div),
    .side_o  (s4_div),
    .quo_o   (q4),
    .rem_o   (r4),
    .den_o   (dn4)
  );

  // final gain
  logic               v4_q;
  logic [15:0]        g4_q, g4_d;
  logic signed [31:0] re4_q, im4_q;
  logic [33:0]        gprod;
  logic               rnd;

  always_comb begin
    rnd   = ({r4, 1'b0} >= {1'b0, dn4});
    gprod = 34'(delta) * 34'(s4_div.e) + 34'd32768;
    unique case (s4_div.mode)
      MODE_BUTTER: g4_d = 16'(q4) + 16'(rnd);
      MODE_GAUSS:  g4_d = lo + 16'(gprod >> 16);
      default:     g4_d = s4_div.gfix;
    endcase
  end

  logic out_v_q;
  out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      sh_v_q  <= '0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v0_q    <= head_valid_i;
      v1_q    <= v1_div;
      sh_v_q  <= {sh_v_q[EXP_STAGES-2:0], v1_q};
      v3_q    <= sh_v_q[EXP_STAGES-1];
      v4_q    <= v4_div;
      out_v_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q       <= s0_d;
      num0_q     <= num0_d;
      den0_q     <= den0_d;
      s1_q       <= s1_div;
      a1_q       <= a1_d;
      op1_q      <= op1_d;
      sh_a_q[0]  <= sh_a_d[0];
      sh_op_q[0] <= op1_q;
      sh_s_q[0]  <= s1_q;
      for (int i = 1; i < EXP_STAGES; i++) begin
        sh_a_q[i]  <= sh_a_d[i];
        sh_op_q[i] <= sh_op_q[i-1];
        sh_s_q[i]  <= sh_s_q[i-1];
      end
      s3_q          <= s3_d;
      num3_q        <= num3_d;
      den3_q        <= den3_d;
      g4_q          <= g4_d;
      re4_q         <= s4_div.re;
      im4_q         <= s4_div.im;
      out_q.re_out  <= signed'(apply_gain(re4_q, g4_q));
      out_q.im_out  <= signed'(apply_gain(im4_q, g4_q));
      out_q.gain    <= g4_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== src/fdfg_checker.sv =====
// Port-level checker for the filter gain block and its bind
`default_nettype none
`include "assert_macros.svh"
module fdfg_sva import fdfg_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input in_t         in_data_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_t        out_data_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [3:0]  cfg_index_i,
  input logic [15:0] cfg_data_i
);

  `FDFG_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled output transfer changed")
  `FDFG_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !out_valid_o && !in_stall_o, "block not idle in reset")
  `FDFG_ASSERT(a_drain, clk_i, rst_ni, !out_stall_i |=> !in_stall_o, "input stalled without output backpressure")
  `FDFG_ASSERT(a_zero_gain, clk_i, rst_ni, out_valid_o && out_data_o.gain == 16'd0 |-> out_data_o.re_out == 32'sd0 && out_data_o.im_out == 32'sd0, "zero gain gave nonzero bin")

endmodule

bind frequency_domain_filter_gain fdfg_sva u_fdfg_sva (.*);
`default_nettype wire

// ===== verif/fdfg_checker.sv =====
// Result checker for the frequency domain filter gain block: predicts gain and scaled bin
`timescale 1ns / 1ps
module fdfg_checker import fdfg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_t        out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [3:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o,
  output int          bins_seen_o
);

  cfg_t  regs;
  out_t  want_q[$];

  localparam logic [15:0] EXP_LUT [16] = '{
    16'd46341, 16'd55109, 16'd60097, 16'd62757, 16'd64132, 16'd64830, 16'd65182, 16'd65359,
    16'd65447, 16'd65492, 16'd65514, 16'd65525, 16'd65530, 16'd65533, 16'd65535, 16'd65535
  };

  function automatic logic [63:0] exp_neg(logic [63:0] x);
    logic [63:0] y, k, f, acc;
    acc = 64'd65536;
    if (x > 64'hFFFF_FFFF) x = 64'hFFFF_FFFF;
    y = (x * 64'd94548) >> 16;
    k = y >> 16;
    if (k >= 17) return 64'd0;
    f = y & 64'hFFFF;
    for (int b = 0; b < 16; b++)
      if (f[15 - b]) acc = (acc * EXP_LUT[b]) >> 16;
    return acc >> k;
  endfunction

  function automatic logic [63:0] butter_q12(logic [63:0] num, logic [63:0] den, int n);
    logic [63:0] r, p, s, q;
    r = (num << 16) / den;
    if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
    p = r;
    for (int i = 1; i < n; i++) begin
      p = (p * r) >> 16;
      if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
    end
    s = 64'd65536 + p;
    q = (64'd1 << 28) / s;
    if (((64'd1 << 28) % s) * 2 >= s) q = q + 1;
    return q;
  endfunction

  function automatic logic [31:0] scale_part(logic [31:0] raw, logic [63:0] g);
    logic [63:0] mag, q;
    mag = raw[31] ? 64'(-raw) & 64'hFFFF_FFFF : 64'(raw);
    q = (mag * g + 64'd2048) >> 12;
    if (raw[31]) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return 32'(-q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return q[31:0];
  endfunction

  function automatic out_t filter_bin(in_t b, cfg_t c);
    logic [63:0] d2, t2, g, hi, lo, sc, e;
    int dx, dy, n;
    logic low_pass;
    logic [1:0] shape;
    out_t o;
    dx = int'(b.col) - int'(WIDTH / 2);
    dy = int'(b.row) - int'(HEIGHT / 2);
    d2 = 64'(dx * dx + dy * dy);
    t2 = (c.cutoff == 0) ? 64'd1 : 64'(c.cutoff) * 64'(c.cutoff);
    g = 64'(ONE_Q12);
    low_pass = (c.filter_kind == FK_LOW);
    if (c.filter_kind == FK_LOW || c.filter_kind == FK_HIGH) begin
      shape = c.homomorphic_enable ? SHAPE_GAUSS : c.shape_kind;
      if (shape == SHAPE_IDEAL) begin
        g = ((d2 <= t2) == low_pass) ? 64'(ONE_Q12) : 64'd0;
      end else if (shape == SHAPE_BUTTER) begin
        n = (c.butter_order == 0) ? 1 : (c.butter_order > 8 ? 8 : int'(c.butter_order));
        if (low_pass) g = butter_q12(d2, t2, n);
        else g = (d2 == 0) ? 64'd0 : butter_q12(t2, d2, n);
      end else begin
        hi = c.homomorphic_enable ? 64'(c.gain_high) : 64'(ONE_Q12);
        lo = c.homomorphic_enable ? 64'(c.gain_low) : 64'd0;
        sc = c.homomorphic_enable ? 64'(c.sharpness) : 64'(ONE_Q12);
        if (lo >= hi) lo = 0;
        e = exp_neg((sc * d2 * 8) / t2);
        if (!low_pass) e = 64'd65536 - e;
        g = lo + (((hi - lo) * e + 64'd32768) >> 16);
      end
    end
    o.re_out = scale_part(b.re_in, g);
    o.im_out = scale_part(b.im_in, g);
    o.gain = g[15:0];
    return o;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors_o++;
  endtask

  assign pending_o = want_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_t w;
    if (!rst_ni) begin
      regs <= CFG_RESET;
      want_q.delete();
      errors_o = 0;
      bins_seen_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) want_q.push_back(filter_bin(in_data_i, regs));
      if (out_valid_i && !out_stall_i) begin
        bins_seen_o <= bins_seen_o + 1;
        if (want_q.size() == 0) begin
          report("unexpected transfer", 64'(out_data_i), 64'd0);
        end else begin
          w = want_q.pop_front();
          if (out_data_i.re_out !== w.re_out) report("re_out", 64'(out_data_i.re_out), 64'(w.re_out));
          if (out_data_i.im_out !== w.im_out) report("im_out", 64'(out_data_i.im_out), 64'(w.im_out));
          if (out_data_i.gain !== w.gain) report("gain", 64'(out_data_i.gain), 64'(w.gain));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_FILTER_KIND: regs.filter_kind <= cfg_data_i[1:0];
          REG_SHAPE_KIND:  regs.shape_kind <= cfg_data_i[1:0];
          REG_HOMOMORPHIC: regs.homomorphic_enable <= cfg_data_i[0];
          REG_CUTOFF:      regs.cutoff <= cfg_data_i[9:0];
          REG_BUTTER_ORD:  regs.butter_order <= cfg_data_i[3:0];
          REG_GAIN_HIGH:   regs.gain_high <= cfg_data_i;
          REG_GAIN_LOW:    regs.gain_low <= cfg_data_i;
          REG_SHARPNESS:   regs.sharpness <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the frequency domain filter gain block: stimulus, settings sweep, verdict
`timescale 1ns / 1ps
module tb_top;
  import fdfg_pkg::*;

  localparam int SETTLE = 150;
  localparam int STUCK_LIMIT = 5000;
  localparam int PHASES = 10;

  logic        clk, rst_n;
  logic        in_valid, in_stall, out_valid, out_stall;
  in_t         in_data;
  out_t        out_data;
  logic        cfg_valid, cfg_ready;
  logic [3:0]  cfg_index;
  logic [15:0] cfg_data;
  int          errors, pending, bins_seen;
  int          idle_cycles;
  bit          calm;

  frequency_domain_filter_gain DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  fdfg_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending), .bins_seen_o(bins_seen)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= STUCK_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stall bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [3:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_bin(in_t b);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic in_t random_bin();
    in_t b;
    int r;
    r = $urandom_range(0, 3);
    b.col = (r == 0) ? 9'($urandom) : 9'(256 + $urandom_range(0, 80) - 40);
    b.row = (r == 0) ? 9'($urandom) : 9'(256 + $urandom_range(0, 80) - 40);
    b.re_in = $urandom;
    b.im_in = $urandom;
    if ($urandom_range(0, 9) == 0) b.re_in = 32'sh8000_0000;
    if ($urandom_range(0, 9) == 0) b.im_in = 32'sh7FFF_FFFF;
    return b;
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic pick_settings(int phase);
    logic [15:0] v;
    write_reg(REG_FILTER_KIND, 16'($urandom_range(0, 3)));
    write_reg(REG_SHAPE_KIND, 16'($urandom_range(0, 3)));
    write_reg(REG_HOMOMORPHIC, 16'($urandom_range(0, 1)));
    case (phase % 4)
      0: v = 16'd0;
      1: v = 16'd1023;
      2: v = 16'd1;
      default: v = 16'($urandom_range(2, 200));
    endcase
    write_reg(REG_CUTOFF, v);
    write_reg(REG_BUTTER_ORD, (phase % 3 == 0) ? 16'($urandom_range(9, 15)) :
                              16'($urandom_range(0, 8)));
    write_reg(REG_GAIN_HIGH, (phase == 1) ? 16'hFFFF : 16'($urandom));
    write_reg(REG_GAIN_LOW, (phase == 2) ? 16'hFFFF : 16'($urandom_range(0, 8191)));
    write_reg(REG_SHARPNESS, (phase == 3) ? 16'hFFFF : (phase == 4) ? 16'd0 : 16'($urandom));
  endtask

  initial begin
    in_t b;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_cycles = 0;
    calm = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: corners, centre and each filter kind
    for (int k = 0; k < 4; k++) begin
      write_reg(REG_FILTER_KIND, 16'(k));
      write_reg(REG_SHAPE_KIND, 16'(k == 3 ? 1 : k));
      b = '{col: 9'd256, row: 9'd256, re_in: 32'sh7FFF_FFFF, im_in: 32'sh8000_0000};
      send_bin(b);
      b = '{col: 9'd0, row: 9'd511, re_in: -32'sd1, im_in: 32'sd1};
      send_bin(b);
      b = '{col: 9'd286, row: 9'd256, re_in: 32'sd12345, im_in: -32'sd2048};
      send_bin(b);
      b = '{col: 9'd511, row: 9'd0, re_in: 32'sh5555_5555, im_in: 32'shAAAA_AAAA};
      send_bin(b);
      drain();
    end

    for (int p = 0; p < PHASES; p++) begin
      pick_settings(p);
      if (p == PHASES - 1) calm = 1'b1;
      for (int i = 0; i < 195; i++) send_bin(random_bin());
      drain();
    end

    $display("covered %0d bins over %0d register settings, incl. cutoff and gain extremes",
             bins_seen, PHASES + 4);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
